### rtl/grdd_pkg.sv
// Package for the grid ray caster: status codes, register indexes and default sizes.
// Used by grdd_if, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package grdd_pkg;
  localparam int GRID_W_DEF = 64;
  localparam int GRID_H_DEF = 64;

  localparam int COORD_W  = 24;
  localparam int DIR_W    = 16;
  localparam int CELL_W   = 6;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BEYOND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd2;

  localparam logic [COORD_W-1:0] CELL_SIZE_RST = 24'd4096;
endpackage
`default_nettype wire

### rtl/grdd_if.sv
// Channel interfaces of the grid ray caster: configuration, input items, results.
// Depends on grdd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface grdd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [grdd_pkg::CFG_IDX_W-1:0]     index;
  logic [grdd_pkg::COORD_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface grdd_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [grdd_pkg::CELL_W-1:0]        cell_x;
  logic [grdd_pkg::CELL_W-1:0]        cell_y;
  logic                               cell_free;
  logic signed [grdd_pkg::COORD_W-1:0] start_x;
  logic signed [grdd_pkg::COORD_W-1:0] start_y;
  logic signed [grdd_pkg::DIR_W-1:0]  dir_x;
  logic signed [grdd_pkg::DIR_W-1:0]  dir_y;
  logic [grdd_pkg::COORD_W-1:0]       max_distance;
  modport source (output valid, kind, cell_x, cell_y, cell_free, start_x, start_y,
                  dir_x, dir_y, max_distance, input ready);
  modport sink   (input valid, kind, cell_x, cell_y, cell_free, start_x, start_y,
                  dir_x, dir_y, max_distance, output ready);
endinterface

interface grdd_out_if;
  logic                               valid;
  logic                               ready;
  logic [grdd_pkg::STATUS_W-1:0]      status;
  logic [grdd_pkg::COORD_W-1:0]       distance;
  modport source (output valid, status, distance, input ready);
  modport sink   (input valid, status, distance, output ready);
endinterface
`default_nettype wire

### rtl/grdd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used for the occupancy grid.
`timescale 1ns / 1ps
`default_nettype none
module grdd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/grdd_div.sv
// Restoring divider, one quotient bit per cycle, with remainder.
// The caller guarantees dividend < divisor * 2^QW. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module grdd_div #(
  parameter int NW = 42,
  parameter int DW = 24,
  parameter int QW = 25
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [QW-1:0]      quot_o,
  output logic [DW-1:0]      rem_o
);
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] sh_q, sh_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, sh_q[QW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    sh_d   = sh_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      rem_d = DW'(dividend_i[NW-1:QW]);
      sh_d  = dividend_i[QW-1:0];
      dvs_d = divisor_i;
      cnt_d = CW'(QW);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_d   = {sh_q[QW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### rtl/grdd_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Stand-alone; VW must be even.
`timescale 1ns / 1ps
`default_nettype none
module grdd_sqrt #(
  parameter int VW = 60
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [VW-1:0] value_i,
  output logic               done_o,
  output logic [VW/2-1:0]    root_o
);
  localparam int RW = VW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [VW-1:0] v_q, v_d, r_q, r_d, b_q, b_d, sum;

  assign sum = r_q + b_q;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    if (start_i) begin
      v_d   = value_i;
      r_d   = '0;
      b_d   = VW'(1) << (VW - 2);
      cnt_d = CW'(RW);
    end else if (cnt_q != '0) begin
      if (v_q >= sum) begin
        v_d = v_q - sum;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d    = b_q >> 2;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[RW-1:0];
endmodule
`default_nettype wire

### rtl/grid_ray_cast_dda_core.sv
// Top level of the grid ray caster: occupancy grid RAM, sequencer and arithmetic units.
// Depends on grdd_pkg, grdd_if, grdd_ram, grdd_div and grdd_sqrt.
//
// The block keeps a GRID_W x GRID_H one-bit occupancy grid in a RAM and casts rays
// through it cell by cell. After reset it clears the grid to blocked, one cell per
// cycle, and accepts no item until the grid is clear; configuration writes are taken
// at any time. A cell write item is written into the grid as it is accepted. A cast
// takes one item at a time: a setup (two divisions for the start cell, a grid read
// and a square root for the ray length factor) and then, per boundary crossed, a
// division that turns the crossing into a distance; at most GRID_W + GRID_H + 4
// boundaries are crossed. A finished result waits in an output register until it
// is taken.
`timescale 1ns / 1ps
`default_nettype none
module grid_ray_cast_dda_core #(
  parameter int GRID_W = grdd_pkg::GRID_W_DEF,
  parameter int GRID_H = grdd_pkg::GRID_H_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  grdd_cfg_if.sink   cfg_i,
  grdd_in_if.sink    in_i,
  grdd_out_if.source out_o
);
  localparam int CXW   = $clog2(GRID_W) + 2;
  localparam int CYW   = $clog2(GRID_H) + 2;
  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int STEPS = GRID_W + GRID_H + 4;
  localparam int ITW   = $clog2(STEPS + 1);
  localparam int EXW   = 24 + ITW + 1;
  localparam int PXW   = EXW + 16;
  localparam int LQW   = 30;
  localparam int NW    = 26;
  localparam int PDW   = NW + LQW;
  localparam int DVW   = PDW - 14;
  localparam int QW    = 25;
  localparam logic [EXW-1:0] NCLAMP = EXW'(1) << 25;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVX  = 4'd2;
  localparam logic [3:0] S_DIVY  = 4'd3;
  localparam logic [3:0] S_RD0   = 4'd4;
  localparam logic [3:0] S_CHK0  = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_MULD  = 4'd9;
  localparam logic [3:0] S_DCHK  = 4'd10;
  localparam logic [3:0] S_DIVD  = 4'd11;
  localparam logic [3:0] S_RD1   = 4'd12;
  localparam logic [3:0] S_CHK1  = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic signed [23:0] origin_x_q, origin_y_q;
  logic [23:0] cell_size_q, cs;

  logic signed [15:0] dx_q, dx_d, dy_q, dy_d;
  logic [15:0] ax, ay;
  logic [23:0] px_q, px_d, py_q, py_d, maxd_q, maxd_d, rx_q, rx_d;
  logic signed [CXW-1:0] cx_q, cx_d;
  logic signed [CYW-1:0] cy_q, cy_d;
  logic [EXW-1:0] ex_q, ex_d, ey_q, ey_d, nsel;
  logic [LQW-1:0] lq_q, lq_d;
  logic [PXW-1:0] prodx_q, prodx_d, prody_q, prody_d;
  logic [NW-1:0] n_q, n_d;
  logic [15:0] asel_q, asel_d;
  logic [PDW-1:0] pd_q, pd_d;
  logic [QW-1:0] d_q, d_d;
  logic [ITW-1:0] iter_q, iter_d;
  logic [2:0] res_status_q, res_status_d, out_status_q, out_status_d;
  logic [23:0] res_dist_q, res_dist_d, out_dist_q, out_dist_d;
  logic out_valid_q, out_valid_d;

  logic signed [24:0] px_full, py_full;
  logic in_acc, take_x, in_grid, wr_ok, sx_pos, sy_pos;
  logic ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr, wr_addr;
  logic div_start, div_done, sq_start, sq_done;
  logic [DVW-1:0] div_dvd;
  logic [23:0] div_dvs, div_rem;
  logic [QW-1:0] div_quot;
  logic [LQW-1:0] sq_root;
  logic [59:0] sq_value;

  assign cs      = (cell_size_q == '0) ? 24'd1 : cell_size_q;
  assign px_full = 25'(in_i.start_x) - 25'(origin_x_q);
  assign py_full = 25'(in_i.start_y) - 25'(origin_y_q);
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign ax = dx_q[15] ? 16'(-dx_q) : 16'(dx_q);
  assign ay = dy_q[15] ? 16'(-dy_q) : 16'(dy_q);
  assign sx_pos = (dx_q != '0) && !dx_q[15];
  assign sy_pos = (dy_q != '0) && !dy_q[15];
  assign sq_value = {32'(ax) * 32'(ax) + 32'(ay) * 32'(ay), 28'b0};

  assign in_grid = (cx_q >= 0) && (cx_q < CXW'(GRID_W)) &&
                   (cy_q >= 0) && (cy_q < CYW'(GRID_H));
  assign ram_raddr = AW'(cy_q) * AW'(GRID_W) + AW'(cx_q);
  assign wr_ok   = (int'(in_i.cell_x) < GRID_W) && (int'(in_i.cell_y) < GRID_H);
  assign wr_addr = AW'(in_i.cell_y) * AW'(GRID_W) + AW'(in_i.cell_x);

  // On a tie the y crossing wins, as does any step when x does not move.
  assign take_x = (dx_q != '0) && ((dy_q == '0) || (prodx_q < prody_q));
  assign nsel   = take_x ? ex_q : ey_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    dx_d = dx_q; dy_d = dy_q; px_d = px_q; py_d = py_q; maxd_d = maxd_q; rx_d = rx_q;
    cx_d = cx_q; cy_d = cy_q; ex_d = ex_q; ey_d = ey_q; lq_d = lq_q;
    prodx_d = prodx_q; prody_d = prody_q; n_d = n_q; asel_d = asel_q;
    pd_d = pd_q; d_d = d_q; iter_d = iter_q;
    res_status_d = res_status_q;
    res_dist_d   = res_dist_q;
    out_status_d = out_status_q;
    out_dist_d   = out_dist_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = in_i.cell_free;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = cs;
    sq_start  = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (!in_i.kind) begin
            ram_we = wr_ok;
          end else begin
            dx_d   = in_i.dir_x;
            dy_d   = in_i.dir_y;
            px_d   = px_full[23:0];
            py_d   = py_full[23:0];
            maxd_d = in_i.max_distance;
            res_dist_d = '0;
            if (in_i.dir_x == '0 && in_i.dir_y == '0) begin
              res_status_d = grdd_pkg::ST_ZERO;
              state_d      = S_FIN;
            end else if (px_full[24] || py_full[24]) begin
              res_status_d = grdd_pkg::ST_OUTSIDE;
              state_d      = S_FIN;
            end else begin
              div_start = 1'b1;
              div_dvd   = DVW'(px_full[23:0]);
              state_d   = S_DIVX;
            end
          end
        end
      end
      S_DIVX: begin
        if (div_done) begin
          if (div_quot >= QW'(GRID_W)) begin
            res_status_d = grdd_pkg::ST_OUTSIDE;
            state_d      = S_FIN;
          end else begin
            cx_d      = CXW'(div_quot);
            rx_d      = div_rem;
            div_start = 1'b1;
            div_dvd   = DVW'(py_q);
            state_d   = S_DIVY;
          end
        end
      end
      S_DIVY: begin
        if (div_done) begin
          if (div_quot >= QW'(GRID_H)) begin
            res_status_d = grdd_pkg::ST_OUTSIDE;
            state_d      = S_FIN;
          end else begin
            cy_d    = CYW'(div_quot);
            // Distance to the first y boundary, by direction of travel.
            ey_d    = sy_pos ? EXW'(cs) - EXW'(div_rem) : EXW'(div_rem);
            state_d = S_RD0;
          end
        end
      end
      S_RD0: begin
        state_d = S_CHK0;
      end
      S_CHK0: begin
        if (!ram_rdata) begin
          res_status_d = grdd_pkg::ST_BLOCKED;
          state_d      = S_FIN;
        end else begin
          ex_d     = sx_pos ? EXW'(cs) - EXW'(rx_q) : EXW'(rx_q);
          iter_d   = '0;
          sq_start = 1'b1;
          state_d  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          lq_d    = sq_root;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prodx_d = PXW'(ex_q) * PXW'(ay);
        prody_d = PXW'(ey_q) * PXW'(ax);
        state_d = S_CMP;
      end
      S_CMP: begin
        n_d = (nsel > NCLAMP) ? NW'(NCLAMP) : NW'(nsel);
        if (take_x) begin
          asel_d = ax;
          cx_d   = sx_pos ? cx_q + 1'b1 : cx_q - 1'b1;
          ex_d   = ex_q + EXW'(cs);
        end else begin
          asel_d = ay;
          cy_d   = sy_pos ? cy_q + 1'b1 : cy_q - 1'b1;
          ey_d   = ey_q + EXW'(cs);
        end
        state_d = S_MULD;
      end
      S_MULD: begin
        pd_d    = PDW'(n_q) * PDW'(lq_q);
        state_d = S_DCHK;
      end
      S_DCHK: begin
        // A quotient of 2^25 or more is always past the maximum distance.
        if (pd_q[PDW-1:14] >= DVW'({asel_q, 25'b0})) begin
          res_status_d = grdd_pkg::ST_BEYOND;
          res_dist_d   = maxd_q;
          state_d      = S_FIN;
        end else begin
          div_start = 1'b1;
          div_dvd   = pd_q[PDW-1:14];
          div_dvs   = 24'(asel_q);
          state_d   = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          d_d = div_quot;
          if (div_quot > QW'(maxd_q)) begin
            res_status_d = grdd_pkg::ST_BEYOND;
            res_dist_d   = maxd_q;
            state_d      = S_FIN;
          end else if (!in_grid) begin
            res_status_d = grdd_pkg::ST_HIT;
            res_dist_d   = div_quot[23:0];
            state_d      = S_FIN;
          end else begin
            state_d = S_RD1;
          end
        end
      end
      S_RD1: begin
        state_d = S_CHK1;
      end
      S_CHK1: begin
        if (!ram_rdata) begin
          res_status_d = grdd_pkg::ST_HIT;
          res_dist_d   = d_q[23:0];
          state_d      = S_FIN;
        end else if (iter_q == ITW'(STEPS - 1)) begin
          res_status_d = grdd_pkg::ST_BEYOND;
          res_dist_d   = maxd_q;
          state_d      = S_FIN;
        end else begin
          iter_d  = iter_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_dist_d   = res_dist_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cell_size_q <= grdd_pkg::CELL_SIZE_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          grdd_pkg::REG_ORIGIN_X:  origin_x_q  <= cfg_i.data;
          grdd_pkg::REG_ORIGIN_Y:  origin_y_q  <= cfg_i.data;
          grdd_pkg::REG_CELL_SIZE: cell_size_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d; dy_q <= dy_d; px_q <= px_d; py_q <= py_d; maxd_q <= maxd_d; rx_q <= rx_d;
    cx_q <= cx_d; cy_q <= cy_d; ex_q <= ex_d; ey_q <= ey_d; lq_q <= lq_d;
    prodx_q <= prodx_d; prody_q <= prody_d; n_q <= n_d; asel_q <= asel_d;
    pd_q <= pd_d; d_q <= d_d; iter_q <= iter_d;
    res_status_q <= res_status_d;
    res_dist_q   <= res_dist_d;
    out_status_q <= out_status_d;
    out_dist_q   <= out_dist_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.distance = out_dist_q;

  grdd_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  grdd_div #(
    .NW(DVW),
    .DW(24),
    .QW(QW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  grdd_sqrt #(
    .VW(60)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .value_i(sq_value),
    .done_o (sq_done),
    .root_o (sq_root)
  );
endmodule
`default_nettype wire

### rtl/grdd_checker.sv
// Port-level checks on the result channel of the grid ray caster, and their bind.
// Depends on grdd_pkg and on grid_ray_cast_dda_core.
`timescale 1ns / 1ps
`default_nettype none
module grdd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_i,
  input wire logic [23:0] distance_i
);
  // A stalled result keeps its value until it is taken.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(distance_i))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == grdd_pkg::ST_HIT) || (status_i == grdd_pkg::ST_BEYOND) ||
                    (status_i == grdd_pkg::ST_ZERO) || (status_i == grdd_pkg::ST_BLOCKED) ||
                    (status_i == grdd_pkg::ST_OUTSIDE))
    else $error("result status out of range");

  a_error_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((status_i == grdd_pkg::ST_ZERO) || (status_i == grdd_pkg::ST_BLOCKED) ||
                    (status_i == grdd_pkg::ST_OUTSIDE)) |-> distance_i == '0)
    else $error("error result carries a distance");
endmodule

bind grid_ray_cast_dda_core grdd_checker u_grdd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .status_i   (out_o.status),
  .distance_i (out_o.distance)
);
`default_nettype wire
